/* rtl/ptest_pkg.sv */
// shared types, constants and the witness base table of the primality tester
`timescale 1ns / 1ps

package ptest_pkg;

   // operand width of the tested value
   localparam int VALUE_WIDTH = 63;
   localparam int BASE_COUNT  = 9;
   localparam int IDX_WIDTH   = $clog2(BASE_COUNT);

   typedef logic [VALUE_WIDTH-1:0] val_type;
   typedef logic [VALUE_WIDTH:0]   wide_type;
   typedef logic [IDX_WIDTH-1:0]   idx_type;

   // command to the shared modular multiplier
   typedef struct packed {
      logic    start;
      val_type x;
      val_type y;
   } mm_cmd_type;

   // status back from the shared modular multiplier
   typedef struct packed {
      logic    done;
      val_type product;
   } mm_sts_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_STRIP,
      ST_BASE,
      ST_POW_MUL,
      ST_POW_MUL_WAIT,
      ST_POW_SQR,
      ST_POW_SQR_WAIT,
      ST_CHECK_ONE,
      ST_CHECK,
      ST_SQR_WAIT,
      ST_NEXT,
      ST_FINISH
   } state_type;

   // fixed witness bases in test order
   function automatic val_type base_value(input idx_type idx);
      val_type b;
      b = '0;
      case (idx)
         idx_type'(0): b = val_type'(2);
         idx_type'(1): b = val_type'(3);
         idx_type'(2): b = val_type'(5);
         idx_type'(3): b = val_type'(7);
         idx_type'(4): b = val_type'(11);
         idx_type'(5): b = val_type'(13);
         idx_type'(6): b = val_type'(29);
         idx_type'(7): b = val_type'(37);
         idx_type'(8): b = val_type'(43);
         default:      b = '0;
      endcase
      return b;
   endfunction

endpackage

/* rtl/primality_test_64bit.sv */
// deterministic miller-rabin primality tester for 63-bit values
`timescale 1ns / 1ps

// Usage: a request on req_* carries one 63-bit candidate; exactly one response
// on rsp_* follows, with bit 0 of rsp_tdata set when the candidate is prime.
// req_tready is high only while the tester is idle; one request is worked on
// at a time. Values 0..3 and even values finish without using the multiplier.
// Otherwise the odd part of n-1 is found one bit per cycle, then for each of up
// to nine bases a square-and-multiply exponentiation and the follow-up squarings
// run on one shared modular multiplier. Each multiply works through its multiplier
// bit by bit and a base needs at most about 124 of them; that multiplier sets the rate.
// The response sits in an output register, so the next request is taken
// while it waits; if the receiver stalls and a second result is ready, the
// tester holds until the first response is taken.
// Synchronous reset returns to idle with no response pending.
module primality_test_64bit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [62:0] candidate, [63] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] is_prime, [7:1] zero
);

   localparam int W = ptest_pkg::VALUE_WIDTH;

   ptest_pkg::state_type state_ff, state_in;
   ptest_pkg::val_type   n_ff, n_in;
   ptest_pkg::val_type   d_ff, d_in;
   ptest_pkg::val_type   e_ff, e_in;
   ptest_pkg::val_type   x_ff, x_in;
   ptest_pkg::val_type   pb_ff, pb_in;
   ptest_pkg::val_type   exp_ff, exp_in;
   ptest_pkg::idx_type   idx_ff, idx_in;
   logic                 verdict_ff, verdict_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_prime_ff, rsp_prime_in;

   ptest_pkg::val_type   nm1;
   ptest_pkg::val_type   base_now;
   ptest_pkg::val_type   e_shift;
   logic                 small_prime;
   logic                 trivial_comp;
   logic                 slot_free;
   ptest_pkg::mm_cmd_type mm_cmd;
   ptest_pkg::mm_sts_type mm_sts;

   // shared modular multiplier
   ptest_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mm_cmd),
      .modulus (n_ff),
      .sts     (mm_sts)
   );

   // decode helpers
   always_comb begin
      nm1          = {n_ff[W-1:1], 1'b0};
      base_now     = ptest_pkg::base_value(idx_ff);
      e_shift      = e_ff >> 1;
      small_prime  = (n_ff == ptest_pkg::val_type'(2)) || (n_ff == ptest_pkg::val_type'(3));
      trivial_comp = (n_ff <= ptest_pkg::val_type'(1)) || !n_ff[0];
      slot_free    = !rsp_valid_ff || rsp_tready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptest_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ptest_pkg::ST_CLASSIFY;
         end
         ptest_pkg::ST_CLASSIFY: begin
            if (small_prime || trivial_comp) state_in = ptest_pkg::ST_FINISH;
            else state_in = ptest_pkg::ST_STRIP;
         end
         ptest_pkg::ST_STRIP: begin
            if (d_ff[0]) state_in = ptest_pkg::ST_BASE;
         end
         ptest_pkg::ST_BASE: begin
            if (base_now >= n_ff) state_in = ptest_pkg::ST_FINISH;
            else state_in = ptest_pkg::ST_POW_MUL;
         end
         ptest_pkg::ST_POW_MUL: begin
            if (e_ff[0]) state_in = ptest_pkg::ST_POW_MUL_WAIT;
            else state_in = ptest_pkg::ST_POW_SQR;
         end
         ptest_pkg::ST_POW_MUL_WAIT: begin
            if (mm_sts.done) state_in = ptest_pkg::ST_POW_SQR;
         end
         ptest_pkg::ST_POW_SQR: begin
            state_in = ptest_pkg::ST_POW_SQR_WAIT;
         end
         ptest_pkg::ST_POW_SQR_WAIT: begin
            if (mm_sts.done) begin
               if (e_shift == '0) state_in = ptest_pkg::ST_CHECK_ONE;
               else state_in = ptest_pkg::ST_POW_MUL;
            end
         end
         ptest_pkg::ST_CHECK_ONE: begin
            if (x_ff == ptest_pkg::val_type'(1)) state_in = ptest_pkg::ST_NEXT;
            else state_in = ptest_pkg::ST_CHECK;
         end
         ptest_pkg::ST_CHECK: begin
            if (x_ff == nm1) state_in = ptest_pkg::ST_NEXT;
            else if (exp_ff == nm1) state_in = ptest_pkg::ST_FINISH;
            else state_in = ptest_pkg::ST_SQR_WAIT;
         end
         ptest_pkg::ST_SQR_WAIT: begin
            if (mm_sts.done) state_in = ptest_pkg::ST_CHECK;
         end
         ptest_pkg::ST_NEXT: begin
            if (idx_ff == ptest_pkg::idx_type'(ptest_pkg::BASE_COUNT - 1)) begin
               state_in = ptest_pkg::ST_FINISH;
            end else begin
               state_in = ptest_pkg::ST_BASE;
            end
         end
         ptest_pkg::ST_FINISH: begin
            if (slot_free) state_in = ptest_pkg::ST_IDLE;
         end
         default: state_in = ptest_pkg::ST_IDLE;
      endcase
   end

   // datapath updates and multiplier commands
   always_comb begin
      n_in         = n_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      x_in         = x_ff;
      pb_in        = pb_ff;
      exp_in       = exp_ff;
      idx_in       = idx_ff;
      verdict_in   = verdict_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mm_cmd.start = 1'b0;
      mm_cmd.x     = x_ff;
      mm_cmd.y     = pb_ff;
      case (state_ff)
         ptest_pkg::ST_IDLE: begin
            n_in = req_tdata[W-1:0];
         end
         ptest_pkg::ST_CLASSIFY: begin
            verdict_in = small_prime;
            d_in       = nm1;
         end
         ptest_pkg::ST_STRIP: begin
            idx_in = '0;
            if (!d_ff[0]) d_in = d_ff >> 1;
         end
         ptest_pkg::ST_BASE: begin
            verdict_in = 1'b1;
            x_in       = ptest_pkg::val_type'(1);
            pb_in      = base_now;
            e_in       = d_ff;
            exp_in     = d_ff;
         end
         ptest_pkg::ST_POW_MUL: begin
            mm_cmd.start = e_ff[0];
         end
         ptest_pkg::ST_POW_MUL_WAIT: begin
            if (mm_sts.done) x_in = mm_sts.product;
         end
         ptest_pkg::ST_POW_SQR: begin
            mm_cmd.start = 1'b1;
            mm_cmd.x     = pb_ff;
         end
         ptest_pkg::ST_POW_SQR_WAIT: begin
            if (mm_sts.done) begin
               pb_in = mm_sts.product;
               e_in  = e_shift;
            end
         end
         ptest_pkg::ST_CHECK: begin
            verdict_in = 1'b0;
            if ((x_ff != nm1) && (exp_ff != nm1)) begin
               mm_cmd.start = 1'b1;
               mm_cmd.y     = x_ff;
               exp_in       = exp_ff << 1;
            end
         end
         ptest_pkg::ST_SQR_WAIT: begin
            if (mm_sts.done) x_in = mm_sts.product;
         end
         ptest_pkg::ST_NEXT: begin
            verdict_in = 1'b1;
            idx_in     = idx_ff + ptest_pkg::idx_type'(1);
         end
         ptest_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_prime_in = verdict_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptest_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      d_ff         <= d_in;
      e_ff         <= e_in;
      x_ff         <= x_in;
      pb_ff        <= pb_in;
      exp_ff       <= exp_in;
      idx_ff       <= idx_in;
      verdict_ff   <= verdict_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   // port outputs
   assign req_tready = (state_ff == ptest_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_prime_ff};

endmodule

/* rtl/ptest_mulmod.sv */
// bit-serial modular multiplier, one bit of the multiplier per cycle
`timescale 1ns / 1ps

module ptest_mulmod (
   input  logic                   clock,
   input  logic                   reset,
   input  ptest_pkg::mm_cmd_type  cmd,
   input  ptest_pkg::val_type     modulus,
   output ptest_pkg::mm_sts_type  sts
);

   ptest_pkg::val_type acc_ff, acc_in;
   ptest_pkg::val_type x_ff, x_in;
   ptest_pkg::val_type y_ff, y_in;
   logic               busy_ff, busy_in;

   ptest_pkg::wide_type sum_acc;
   ptest_pkg::wide_type dbl_x;
   ptest_pkg::wide_type mod_wide;

   // add and double, each reduced by one conditional subtract
   always_comb begin
      mod_wide = {1'b0, modulus};
      sum_acc  = {1'b0, acc_ff} + {1'b0, x_ff};
      dbl_x    = {x_ff, 1'b0};
      if (sum_acc >= mod_wide) begin
         sum_acc = sum_acc - mod_wide;
      end
      if (dbl_x >= mod_wide) begin
         dbl_x = dbl_x - mod_wide;
      end
   end

   // iteration control
   always_comb begin
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      busy_in = busy_ff;
      if (cmd.start) begin
         acc_in  = '0;
         x_in    = cmd.x;
         y_in    = cmd.y;
         busy_in = 1'b1;
      end else if (busy_ff && (y_ff == '0)) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (y_ff[0]) begin
            acc_in = sum_acc[ptest_pkg::VALUE_WIDTH-1:0];
         end
         x_in = dbl_x[ptest_pkg::VALUE_WIDTH-1:0];
         y_in = y_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign sts.done    = busy_ff && (y_ff == '0);
   assign sts.product = acc_ff;

endmodule

/* tb/primality_test_64bit_tb.sv */
// self-checking testbench for the 63-bit miller-rabin primality tester
`timescale 1ns / 1ps

module primality_test_64bit_tb;

   // longest stretch without any handshake before the run is abandoned
   localparam int IDLE_LIMIT    = 600000;
   localparam int DRAIN_CYCLES  = 50;
   localparam int RANDOM_COUNT  = 80;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [62:0] candidate, [63] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] is_prime, [7:1] zero

   // candidates waiting to be sent and verdicts waiting to come back
   ptest_pkg::val_type candidate_q[$];
   logic               verdict_q[$];

   int unsigned witness_list [ptest_pkg::BASE_COUNT] = '{2, 3, 5, 7, 11, 13, 29, 37, 43};

   int          send_gap   = 0;
   int          ready_hold = 0;
   int          idle_cycles = 0;
   int          mismatches = 0;

   primality_test_64bit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // (x * y) mod m by doubling and adding, sums kept in 64 bits
   function automatic ptest_pkg::wide_type mulmod(input ptest_pkg::wide_type x,
                                                  input ptest_pkg::wide_type y,
                                                  input ptest_pkg::wide_type m);
      ptest_pkg::wide_type acc;
      acc = '0;
      while (y != 0) begin
         if (y[0])
            acc = (acc + x) % m;
         x = (x + x) % m;
         y = y >> 1;
      end
      return acc;
   endfunction

   // (b ^ e) mod m by square and multiply
   function automatic ptest_pkg::wide_type powmod(input ptest_pkg::wide_type b,
                                                  input ptest_pkg::wide_type e,
                                                  input ptest_pkg::wide_type m);
      ptest_pkg::wide_type acc;
      acc = ptest_pkg::wide_type'(1) % m;
      while (e != 0) begin
         if (e[0])
            acc = mulmod(acc, b, m);
         b = mulmod(b, b, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // expected verdict for one candidate
   function automatic logic prime_verdict(input ptest_pkg::val_type n);
      ptest_pkg::wide_type m, nm1, odd_part, x, e, b;
      m = {1'b0, n};
      if (m == 2 || m == 3)
         return 1'b1;
      if (m <= 1 || !m[0])
         return 1'b0;
      nm1 = m - 1;
      odd_part = nm1;
      while (!odd_part[0])
         odd_part = odd_part >> 1;
      for (int i = 0; i < ptest_pkg::BASE_COUNT; i++) begin
         b = ptest_pkg::wide_type'(witness_list[i]);
         if (b >= m)
            return 1'b1;
         x = powmod(b, odd_part, m);
         if (x != 1) begin
            e = odd_part;
            while (e != nm1 && x != nm1) begin
               x = mulmod(x, x, m);
               e = e << 1;
            end
            if (x != nm1)
               return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // mostly small operands so the run stays short, a few at full width
   function automatic ptest_pkg::val_type random_candidate();
      ptest_pkg::wide_type raw, v;
      int pick, w;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return ptest_pkg::val_type'($urandom_range(0, 63));
      if (pick < 16) begin
         w = $urandom_range(2, 63);
         v = raw & ((ptest_pkg::wide_type'(1) << w) - 1);
         v[0] = 1'b0;
         return ptest_pkg::val_type'(v);
      end
      if (pick < 88)
         w = $urandom_range(5, 20);
      else if (pick < 96)
         w = $urandom_range(21, 36);
      else
         w = 63;
      v = raw & ((ptest_pkg::wide_type'(1) << w) - 1);
      v[w-1] = 1'b1;
      v[0]   = 1'b1;
      return ptest_pkg::val_type'(v);
   endfunction

   // idle length: many zero, most short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            verdict_q.push_back(prime_verdict(req_tdata[ptest_pkg::VALUE_WIDTH-1:0]));
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               req_tvalid <= 1'b0;
               send_gap   <= send_gap - 1;
            end else if (candidate_q.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, candidate_q.pop_front()};
               send_gap   <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response back-pressure: mostly ready, short stalls, now and then a long one
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(1, 12);
         end else if (r < 90) begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(1, 4);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(20, 200);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            $error("unexpected response: is_prime %0b", rsp_tdata[0]);
            mismatches++;
         end else begin
            logic want;
            want = verdict_q.pop_front();
            if (rsp_tdata[0] !== want) begin
               $error("is_prime mismatch: expected %0b, actual %0b", want, rsp_tdata[0]);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      // directed: edge values, small primes around the base table,
      // strong pseudoprimes, widest operands
      candidate_q.push_back(ptest_pkg::val_type'(0));
      candidate_q.push_back(ptest_pkg::val_type'(1));
      candidate_q.push_back(ptest_pkg::val_type'(2));
      candidate_q.push_back(ptest_pkg::val_type'(3));
      candidate_q.push_back(ptest_pkg::val_type'(4));
      candidate_q.push_back(ptest_pkg::val_type'(5));
      candidate_q.push_back(ptest_pkg::val_type'(9));
      candidate_q.push_back(ptest_pkg::val_type'(25));
      candidate_q.push_back(ptest_pkg::val_type'(41));
      candidate_q.push_back(ptest_pkg::val_type'(43));
      candidate_q.push_back(ptest_pkg::val_type'(47));
      candidate_q.push_back(ptest_pkg::val_type'(561));
      candidate_q.push_back(ptest_pkg::val_type'(2047));
      candidate_q.push_back(ptest_pkg::val_type'(1373653));
      candidate_q.push_back(ptest_pkg::val_type'(25326001));
      candidate_q.push_back(ptest_pkg::val_type'(64'd3215031751));
      candidate_q.push_back(ptest_pkg::val_type'(64'd2147483647));
      candidate_q.push_back(ptest_pkg::val_type'(64'd3825123056546413051));
      candidate_q.push_back(ptest_pkg::val_type'(64'h4000_0000_0000_0000));
      candidate_q.push_back(ptest_pkg::val_type'(64'h7FFF_FFFF_FFFF_FFFF));
      candidate_q.push_back(ptest_pkg::val_type'(64'h7FFF_FFFF_FFFF_FFE7));
      for (int i = 0; i < RANDOM_COUNT; i++)
         candidate_q.push_back(random_candidate());

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // wait for every request to go out and every verdict to come back
      @(negedge clock);
      while (candidate_q.size() != 0 || req_tvalid || verdict_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
